/* sv/vmcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmcd_pkg
// Shared constants, types and helpers of the vector magnitude cap/decay core.
// ----------------------------------------------------------------------------
package vmcd_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int SQRT_STAGES   = 16;
  localparam int DIV_STAGES    = 32;
  localparam int DEC_MIN_MAG   = 5;

  localparam logic [15:0] DECAY_SCALE_RESET = 16'd1000;
  localparam logic signed [15:0] SAT_POS = 16'sd32767;
  localparam logic signed [15:0] SAT_NEG = -16'sd32767;

  typedef enum logic [2:0] {
    MODE_PASS  = 3'b001,
    MODE_ZERO  = 3'b010,
    MODE_SCALE = 3'b100
  } mode_e;

  // fields carried alongside the magnitude pipeline
  typedef struct packed {
    logic               act;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] amt;
  } in_side_t;

  // fields carried alongside the divider pipeline
  typedef struct packed {
    mode_e              mode;
    logic               use_amt;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] amt;
    logic [15:0]        mag;
    logic               neg_x;
    logic               neg_y;
    logic               neg_p;
    logic               scale_zero;
  } div_side_t;

  function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
    logic signed [15:0] r;
    if (v > 50'(SAT_POS)) begin
      r = SAT_POS;
    end else if (v < 50'(SAT_NEG)) begin
      r = SAT_NEG;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/vmcd_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmcd_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module vmcd_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] rad_i,
  output logic [15:0] root_o
);
  import vmcd_pkg::*;

  logic [17:0] rem_q  [SQRT_STAGES];
  logic [17:0] rem_d  [SQRT_STAGES];
  logic [15:0] root_q [SQRT_STAGES];
  logic [15:0] root_d [SQRT_STAGES];
  logic [31:0] n_q    [SQRT_STAGES];
  logic [31:0] n_d    [SQRT_STAGES];

  always_comb begin
    logic [17:0] r_in;
    logic [15:0] t_in;
    logic [31:0] n_in;
    logic [17:0] pre;
    logic [17:0] trial;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (k == 0) begin
        r_in = '0;
        t_in = '0;
        n_in = rad_i;
      end else begin
        r_in = rem_q[k-1];
        t_in = root_q[k-1];
        n_in = n_q[k-1];
      end
      // bring down the next bit pair, try root*4+1
      pre   = {r_in[15:0], n_in[31:30]};
      trial = {t_in, 2'b01};
      if (pre >= trial) begin
        rem_d[k]  = pre - trial;
        root_d[k] = {t_in[14:0], 1'b1};
      end else begin
        rem_d[k]  = pre;
        root_d[k] = {t_in[14:0], 1'b0};
      end
      n_d[k] = {n_in[29:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      n_q    <= n_d;
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule
`default_nettype wire

/* sv/vmcd_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmcd_div
// Pipelined unsigned 32 by 16 restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vmcd_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] num_i,
  input  logic [15:0] den_i,
  output logic [31:0] quo_o
);
  import vmcd_pkg::*;

  logic [15:0] rem_q [DIV_STAGES];
  logic [15:0] rem_d [DIV_STAGES];
  logic [31:0] n_q   [DIV_STAGES];
  logic [31:0] n_d   [DIV_STAGES];
  logic [15:0] d_q   [DIV_STAGES];
  logic [15:0] d_d   [DIV_STAGES];

  always_comb begin
    logic [15:0] r_in;
    logic [31:0] n_in;
    logic [15:0] dv;
    logic [16:0] pre;
    logic [16:0] diff;
    logic        ge;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        r_in = '0;
        n_in = num_i;
        dv   = den_i;
      end else begin
        r_in = rem_q[k-1];
        n_in = n_q[k-1];
        dv   = d_q[k-1];
      end
      pre  = {r_in, n_in[31]};
      diff = pre - {1'b0, dv};
      ge   = (pre >= {1'b0, dv});
      rem_d[k] = ge ? diff[15:0] : pre[15:0];
      // quotient bits fill in from the bottom as the dividend shifts out
      n_d[k] = {n_in[30:0], ge};
      d_d[k] = dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      n_q   <= n_d;
      d_q   <= d_d;
    end
  end

  assign quo_o = n_q[DIV_STAGES-1];

endmodule
`default_nettype wire

/* sv/vector_magnitude_cap_decay_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_magnitude_cap_decay_core
// Caps or decays the length of a signed 2D vector, one word per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// A new word is taken every cycle unless a stalled output holds it; the
// pipeline holds a 16-stage square root, a 32-stage divider and seven
// staging registers. A stalled output freezes the whole pipeline, so no word
// is lost or repeated. decay_scale is read by words in flight; the user must
// write it only while the pipeline is empty, the block does not enforce it.
module vector_magnitude_cap_decay_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic signed [15:0]  vec_x_i,
  input  logic signed [15:0]  vec_y_i,
  input  logic signed [15:0]  amount_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  res_x_o,
  output logic signed [15:0]  res_y_o,
  output logic [15:0]         in_magnitude_o
);
  import vmcd_pkg::*;

  logic        en;
  logic [15:0] decay_scale_q;

  logic                a_valid_q, b_valid_q, c_valid_q;
  in_side_t            a_side_q, b_side_q, c_side_q;
  logic [31:0]         xx_q, yy_q, sq_q;
  logic                q_valid_q [SQRT_STAGES];
  in_side_t            q_side_q  [SQRT_STAGES];
  logic [15:0]         root;

  logic                p_valid_q;
  div_side_t           p_side_q, p_side_d;
  logic [31:0]         p_numx_q, p_numy_q, p_nump_q;
  logic [31:0]         p_numx_d, p_numy_d, p_nump_d;
  logic signed [32:0]  prod;

  logic                d_valid_q [DIV_STAGES];
  div_side_t           d_side_q  [DIV_STAGES];
  logic [31:0]         qx, qy, qp;

  logic                e_valid_q;
  div_side_t           e_side_q;
  logic signed [17:0]  e_ux_q, e_uy_q, e_ux_d, e_uy_d;
  logic [30:0]         e_s_q, e_s_d;
  logic signed [32:0]  frac, s_full;

  logic                f_valid_q;
  div_side_t           f_side_q;
  logic signed [49:0]  f_px_q, f_py_q;

  logic                out_valid_q;
  logic signed [15:0]  res_x_q, res_y_q, res_x_d, res_y_d;
  logic [15:0]         mag_q;
  logic signed [49:0]  sh_x, sh_y;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_scale_q <= DECAY_SCALE_RESET;
    end else if (cfg_we_i) begin
      decay_scale_q <= cfg_wdata_i;
    end
  end

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      p_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      f_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < SQRT_STAGES; k++) q_valid_q[k] <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) d_valid_q[k] <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      q_valid_q[0] <= c_valid_q;
      for (int k = 1; k < SQRT_STAGES; k++) q_valid_q[k] <= q_valid_q[k-1];
      p_valid_q <= q_valid_q[SQRT_STAGES-1];
      d_valid_q[0] <= p_valid_q;
      for (int k = 1; k < DIV_STAGES; k++) d_valid_q[k] <= d_valid_q[k-1];
      e_valid_q   <= d_valid_q[DIV_STAGES-1];
      f_valid_q   <= e_valid_q;
      out_valid_q <= f_valid_q;
    end
  end

  // squares and magnitude
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_side_q <= '{act: action_i, x: vec_x_i, y: vec_y_i, amt: amount_i};
      b_side_q <= a_side_q;
      xx_q     <= 32'(a_side_q.x * a_side_q.x);
      yy_q     <= 32'(a_side_q.y * a_side_q.y);
      c_side_q <= b_side_q;
      sq_q     <= xx_q + yy_q;
      q_side_q[0] <= c_side_q;
      for (int k = 1; k < SQRT_STAGES; k++) q_side_q[k] <= q_side_q[k-1];
    end
  end

  vmcd_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sq_q),
    .root_o (root)
  );

  // mode decision and divider operands
  always_comb begin
    in_side_t    s;
    logic [15:0] ax, ay;
    s    = q_side_q[SQRT_STAGES-1];
    ax   = s.x[15] ? 16'(~s.x + 16'sd1) : s.x;
    ay   = s.y[15] ? 16'(~s.y + 16'sd1) : s.y;
    prod = $signed({1'b0, root}) * s.amt;

    p_side_d.x          = s.x;
    p_side_d.y          = s.y;
    p_side_d.amt        = s.amt;
    p_side_d.mag        = root;
    p_side_d.neg_x      = s.x[15];
    p_side_d.neg_y      = s.y[15];
    p_side_d.neg_p      = prod[32];
    p_side_d.scale_zero = (decay_scale_q == '0);
    if (!s.act) begin
      p_side_d.use_amt = 1'b1;
      if (!s.amt[15] && (root > {1'b0, s.amt[14:0]})) begin
        p_side_d.mode = MODE_SCALE;
      end else begin
        p_side_d.mode = MODE_PASS;
      end
    end else begin
      p_side_d.use_amt = 1'b0;
      if (root < 16'(DEC_MIN_MAG)) begin
        p_side_d.mode = MODE_ZERO;
      end else begin
        p_side_d.mode = MODE_SCALE;
      end
    end

    p_numx_d = 32'(ax) << FRACTION_BITS;
    p_numy_d = 32'(ay) << FRACTION_BITS;
    p_nump_d = prod[32] ? 32'(-prod) : prod[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_side_q <= p_side_d;
      p_numx_q <= p_numx_d;
      p_numy_q <= p_numy_d;
      p_nump_q <= p_nump_d;
      d_side_q[0] <= p_side_q;
      for (int k = 1; k < DIV_STAGES; k++) d_side_q[k] <= d_side_q[k-1];
    end
  end

  vmcd_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (p_numx_q),
    .den_i (p_side_q.mag),
    .quo_o (qx)
  );

  vmcd_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (p_numy_q),
    .den_i (p_side_q.mag),
    .quo_o (qy)
  );

  vmcd_div u_div_p (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (p_nump_q),
    .den_i (decay_scale_q),
    .quo_o (qp)
  );

  // unit vector and target length
  always_comb begin
    div_side_t s;
    s      = d_side_q[DIV_STAGES-1];
    e_ux_d = s.neg_x ? -$signed({1'b0, qx[16:0]}) : $signed({1'b0, qx[16:0]});
    e_uy_d = s.neg_y ? -$signed({1'b0, qy[16:0]}) : $signed({1'b0, qy[16:0]});
    if (s.scale_zero) begin
      frac = '0;
    end else begin
      frac = s.neg_p ? -$signed({1'b0, qp}) : $signed({1'b0, qp});
    end
    s_full = $signed({17'b0, s.mag}) - frac;
    if (s.use_amt) begin
      e_s_d = 31'(s.amt[14:0]);
    end else if (s_full[32]) begin
      e_s_d = '0;
    end else begin
      e_s_d = s_full[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_side_q <= d_side_q[DIV_STAGES-1];
      e_ux_q   <= e_ux_d;
      e_uy_q   <= e_uy_d;
      e_s_q    <= e_s_d;
      f_side_q <= e_side_q;
      f_px_q   <= e_ux_q * $signed({1'b0, e_s_q});
      f_py_q   <= e_uy_q * $signed({1'b0, e_s_q});
    end
  end

  // floor shift, saturate, select
  always_comb begin
    sh_x = f_px_q >>> FRACTION_BITS;
    sh_y = f_py_q >>> FRACTION_BITS;
    case (f_side_q.mode)
      MODE_SCALE: begin
        res_x_d = sat16(sh_x);
        res_y_d = sat16(sh_y);
      end
      MODE_ZERO: begin
        res_x_d = '0;
        res_y_d = '0;
      end
      default: begin
        res_x_d = sat16({{34{f_side_q.x[15]}}, f_side_q.x});
        res_y_d = sat16({{34{f_side_q.y[15]}}, f_side_q.y});
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_x_q <= res_x_d;
      res_y_q <= res_y_d;
      mag_q   <= f_side_q.mag;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign res_x_o        = res_x_q;
  assign res_y_o        = res_y_q;
  assign in_magnitude_o = mag_q;

`ifndef SYNTH
  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (in_magnitude_o <= 16'd46341))
    else $error("magnitude out of range");

  a_res_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (res_x_o != 16'sh8000) && (res_y_o != 16'sh8000))
    else $error("result not saturated");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");
`endif

endmodule
`default_nettype wire
